/* sv/burkes_mono_dither_top_defines.svh */
// assertion macros for the burkes mono dither block
// included by burkes_mono_dither_top.sv; no other dependencies
`ifndef BURKES_MONO_DITHER_TOP_DEFINES_SVH
`define BURKES_MONO_DITHER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge out of reset
`define BMD_ASSERT_ALWAYS(label, clock, reset, cond) \
  label: assert property (@(posedge clock) disable iff (reset) (cond)) \
    else $error("burkes dither: invariant violated");

// antecedent at one edge implies consequent at the next edge
`define BMD_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("burkes dither: next-cycle check failed");

`else

`define BMD_ASSERT_ALWAYS(label, clock, reset, cond)
`define BMD_ASSERT_NEXT(label, clock, reset, ante, cons)

`endif

`endif

/* sv/bmd_pkg.sv */
// shared types, constants and arithmetic helpers for the burkes mono dither block
// no dependencies
package bmd_pkg;

  localparam int ERR_W = 12;
  typedef logic signed [ERR_W-1:0] err_t;

  localparam int LUMA_W = 18;
  typedef logic [LUMA_W-1:0] luma_t;

  // luma plus error in 10-bit fixed point, signed
  localparam int CUR_W = 23;
  typedef logic signed [CUR_W-1:0] cur_t;

  localparam int FRAC_BITS = 10;
  localparam luma_t COEF_RED   = 18'd306;
  localparam luma_t COEF_GREEN = 18'd601;
  localparam luma_t COEF_BLUE  = 18'd117;
  localparam luma_t FULL_WHITE = 18'd261120;

  // shares of k/32 on a 10-bit fraction value: shift by 15 - log2(k)
  localparam int SHIFT_K8 = 12;
  localparam int SHIFT_K4 = 13;
  localparam int SHIFT_K2 = 14;

  localparam int DEFAULT_MAX_WIDTH = 512;

  localparam int CFG_W = 10;
  localparam logic [7:0] THRESHOLD_RESET = 8'd180;
  localparam logic [9:0] WIDTH_RESET     = 10'd280;

  localparam logic REG_WHITE_THRESHOLD = 1'b0;
  localparam logic REG_LINE_WIDTH      = 1'b1;

  localparam err_t ERR_MAX = 12'sd2047;
  localparam err_t ERR_MIN = -12'sd2048;

  // saturating 12-bit add
  function automatic err_t sat_add(err_t a, err_t b);
    logic signed [ERR_W:0] s;
    err_t r;
    s = (ERR_W+1)'(a) + (ERR_W+1)'(b);
    if (s[ERR_W] != s[ERR_W-1]) begin
      r = s[ERR_W] ? ERR_MIN : ERR_MAX;
    end else begin
      r = s[ERR_W-1:0];
    end
    return r;
  endfunction

  // burkes share truncated toward zero
  function automatic err_t share(cur_t c, int unsigned sh);
    logic [CUR_W-1:0] mag;
    logic [CUR_W-1:0] q;
    err_t qe;
    mag = c[CUR_W-1] ? CUR_W'(-c) : CUR_W'(c);
    q = mag >> sh;
    qe = err_t'(q[ERR_W-1:0]);
    return c[CUR_W-1] ? -qe : qe;
  endfunction

endpackage

/* sv/burkes_mono_dither_top.sv */
// burkes error-diffusion dither from rgb pixels to one black/white bit per pixel
// depends on bmd_pkg and burkes_mono_dither_top_defines.svh
`include "burkes_mono_dither_top_defines.svh"

// Takes one rgb pixel per clock in raster order and returns one bit per pixel,
// 1 for white and 0 for black, in the same order. A transaction on the input
// side is accepted when in_valid is high and in_stall is low; the pixel is
// registered in the input stage, its result on pixel_white/out_valid, held while
// out_stall is high, while the block keeps taking a new pixel on every clock
// as long as the output register is free or being emptied. Sustained rate is
// one pixel per clock, set by the single processing stage and the line store's
// single write port; the two extra row-end writes go through a two-entry write
// queue that drains in the next row's first columns or in any idle clock.
// frame_start on a pixel restarts the image at that pixel. The line store
// needs no clearing pass after reset: the first row of each frame reads it as
// zero. white_threshold and line_width are written by the user through
// cfg_write/cfg_index/cfg_data only while no pixel is in flight, which the
// block does not enforce; line_width 0 acts as 1, above MAX_WIDTH as MAX_WIDTH.
module burkes_mono_dither_top #(
  parameter int MAX_WIDTH = bmd_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  // pixel input
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               red,
  input  logic [7:0]               green,
  input  logic [7:0]               blue,
  input  logic                     frame_start,
  // result output
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     pixel_white,
  // configuration writes
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [bmd_pkg::CFG_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;

  typedef logic [CW-1:0] col_t;

  // one pending line store write
  typedef struct packed {
    logic          valid;
    col_t          addr;
    bmd_pkg::err_t data;
  } wr_t;

  // configuration registers
  logic [7:0] white_threshold;
  logic [9:0] line_width;

  // handshake
  logic in_accept;
  logic s1_fire;

  // input stage
  logic            s1_valid;
  bmd_pkg::luma_t  s1_luma;
  logic            s1_frame_start;
  bmd_pkg::luma_t  luma_in;

  // row state
  col_t            column_index;
  logic            on_first_row;
  bmd_pkg::err_t   below_window [4];
  bmd_pkg::err_t   right_carry [2];

  // line store, its read register and forwarded value
  bmd_pkg::err_t   mem [MAX_WIDTH];
  bmd_pkg::err_t   rd_data;
  logic            fwd_hit;
  bmd_pkg::err_t   fwd_data;
  logic            fwd_hit_next;
  bmd_pkg::err_t   fwd_data_next;

  // write queue
  wr_t             wq [2];
  wr_t             wq_next [2];
  wr_t             wr_head;
  wr_t             list [5];
  logic [4:0]      list_valid;
  logic [2:0]      n_seen;

  // processing
  col_t            x;
  logic            first;
  bmd_pkg::err_t   bw_e [4];
  bmd_pkg::err_t   rc_e [2];
  bmd_pkg::err_t   line_val;
  bmd_pkg::err_t   err;
  bmd_pkg::cur_t   cur;
  bmd_pkg::cur_t   thr;
  bmd_pkg::cur_t   res;
  logic            white;
  bmd_pkg::err_t   s2;
  bmd_pkg::err_t   s4;
  bmd_pkg::err_t   s8;
  bmd_pkg::err_t   bw_out;
  bmd_pkg::err_t   bw_next [4];
  bmd_pkg::err_t   rc_next [2];
  logic [WW-1:0]   wid;
  logic [WW-1:0]   x_plus;
  logic [31:0]     lw32;
  logic            last;
  col_t            col_next;
  logic            first_next;
  col_t            rd_addr;
  wr_t             wa;
  wr_t             wb;
  wr_t             wc;

  // ---------------------------------------------------------------------------
  // handshake: output register frees the input stage
  // ---------------------------------------------------------------------------
  assign s1_fire   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  // luma in 10-bit fixed point, registered with the pixel
  assign luma_in = bmd_pkg::luma_t'(red)   * bmd_pkg::COEF_RED
                 + bmd_pkg::luma_t'(green) * bmd_pkg::COEF_GREEN
                 + bmd_pkg::luma_t'(blue)  * bmd_pkg::COEF_BLUE;

  // ---------------------------------------------------------------------------
  // effective row width
  // ---------------------------------------------------------------------------
  always_comb begin
    lw32 = 32'(line_width);
    if (line_width == '0) begin
      wid = WW'(1);
    end else if (lw32 > 32'(MAX_WIDTH)) begin
      wid = WW'(MAX_WIDTH);
    end else begin
      wid = WW'(lw32);
    end
  end

  // ---------------------------------------------------------------------------
  // processing of the pixel in the input stage
  // ---------------------------------------------------------------------------
  always_comb begin
    // frame start clears the row state before the pixel is used
    x     = s1_frame_start ? '0 : column_index;
    first = s1_frame_start | on_first_row;
    for (int i = 0; i < 4; i++) begin
      bw_e[i] = s1_frame_start ? '0 : below_window[i];
    end
    for (int i = 0; i < 2; i++) begin
      rc_e[i] = s1_frame_start ? '0 : right_carry[i];
    end

    // line store reads as zero on a frame's first row
    line_val = first ? '0 : (fwd_hit ? fwd_data : rd_data);
    err      = bmd_pkg::sat_add(line_val, rc_e[0]);

    cur   = bmd_pkg::cur_t'({1'b0, s1_luma})
          + (bmd_pkg::cur_t'(err) <<< bmd_pkg::FRAC_BITS);
    thr   = bmd_pkg::cur_t'({white_threshold, 10'b0});
    white = cur >= thr;
    res   = white ? cur - bmd_pkg::cur_t'(bmd_pkg::FULL_WHITE) : cur;

    s2 = bmd_pkg::share(res, bmd_pkg::SHIFT_K2);
    s4 = bmd_pkg::share(res, bmd_pkg::SHIFT_K4);
    s8 = bmd_pkg::share(res, bmd_pkg::SHIFT_K8);

    // next-row window slides one column, column x-2 leaves it
    bw_out     = bmd_pkg::sat_add(bw_e[0], s2);
    bw_next[0] = bmd_pkg::sat_add(bw_e[1], s4);
    bw_next[1] = bmd_pkg::sat_add(bw_e[2], s8);
    bw_next[2] = bmd_pkg::sat_add(bw_e[3], s4);
    bw_next[3] = s2;

    rc_next[0] = bmd_pkg::sat_add(rc_e[1], s8);
    rc_next[1] = s4;

    x_plus = WW'(x) + WW'(1);
    last   = x_plus >= wid;

    // line store writes caused by this pixel, oldest first
    wa.valid = s1_fire && (x >= col_t'(2));
    wa.addr  = x - col_t'(2);
    wa.data  = bw_out;
    wb.valid = s1_fire && last && (x != '0);
    wb.addr  = x - col_t'(1);
    wb.data  = bw_next[0];
    wc.valid = s1_fire && last;
    wc.addr  = x;
    wc.data  = bw_next[1];

    // state seen by the next pixel
    if (s1_fire) begin
      col_next   = last ? '0 : col_t'(x_plus);
      first_next = last ? 1'b0 : first;
    end else begin
      col_next   = column_index;
      first_next = on_first_row;
    end
    rd_addr = frame_start ? '0 : col_next;
  end

  // ---------------------------------------------------------------------------
  // write queue: one write reaches the store per clock, the rest wait
  // ---------------------------------------------------------------------------
  always_comb begin
    list[0] = wq[0];
    list[1] = wq[1];
    list[2] = wa;
    list[3] = wb;
    list[4] = wc;

    wr_head    = '0;
    wq_next[0] = '0;
    wq_next[1] = '0;
    n_seen     = '0;
    fwd_hit_next  = 1'b0;
    fwd_data_next = '0;
    for (int i = 0; i < 5; i++) begin
      list_valid[i] = list[i].valid;
      if (list[i].valid) begin
        if (n_seen == 3'd0) begin
          wr_head = list[i];
        end else if (n_seen == 3'd1) begin
          wq_next[0] = list[i];
        end else if (n_seen == 3'd2) begin
          wq_next[1] = list[i];
        end
        n_seen = n_seen + 3'd1;
      end
      // newest pending write to the read column wins over the store
      if (list[i].valid && (list[i].addr == rd_addr)) begin
        fwd_hit_next  = 1'b1;
        fwd_data_next = list[i].data;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // line store
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_head.valid) begin
      mem[wr_head.addr] <= wr_head.data;
    end
    if (in_accept) begin
      rd_data <= mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_luma        <= luma_in;
      s1_frame_start <= frame_start;
      fwd_hit        <= fwd_hit_next;
      fwd_data       <= fwd_data_next;
    end
    if (s1_fire) begin
      pixel_white <= white;
    end
  end

  // ---------------------------------------------------------------------------
  // control and row state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      column_index    <= '0;
      on_first_row    <= 1'b1;
      white_threshold <= bmd_pkg::THRESHOLD_RESET;
      line_width      <= bmd_pkg::WIDTH_RESET;
      for (int i = 0; i < 4; i++) begin
        below_window[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        right_carry[i] <= '0;
        wq[i]          <= '0;
      end
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      column_index <= col_next;
      on_first_row <= first_next;
      wq[0]        <= wq_next[0];
      wq[1]        <= wq_next[1];

      if (s1_fire) begin
        for (int i = 0; i < 4; i++) begin
          below_window[i] <= last ? '0 : bw_next[i];
        end
        for (int i = 0; i < 2; i++) begin
          right_carry[i] <= last ? '0 : rc_next[i];
        end
      end

      if (cfg_write) begin
        unique case (cfg_index)
          bmd_pkg::REG_WHITE_THRESHOLD: begin
            white_threshold <= cfg_data[7:0];
          end
          bmd_pkg::REG_LINE_WIDTH: begin
            line_width <= cfg_data;
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // row-end writes never outrun the store port plus the two-entry queue
  `BMD_ASSERT_ALWAYS(a_queue_fits, clk, rst, $countones(list_valid) <= 3)
  // store writes stay inside the row storage
  `BMD_ASSERT_ALWAYS(a_wr_range, clk, rst, !wr_head.valid || (32'(wr_head.addr) < MAX_WIDTH))
  // a finished row restarts at column zero off the first row
  `BMD_ASSERT_NEXT(a_row_end, clk, rst, s1_fire && last, column_index == '0 && !on_first_row)

endmodule
